>>> rtl/tce_pkg.sv
// Shared constants and types for the text console engine.
`timescale 1ns / 1ps
`default_nettype none

package tce_pkg;

    // Default screen geometry
    localparam int DEF_SCREEN_COLUMNS = 80;
    localparam int DEF_SCREEN_ROWS    = 25;

    // Character codes
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_BS    = 8'h08;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    // Attribute reset values
    localparam logic [7:0] TEXT_ATTR_RESET   = 8'h70;
    localparam logic [7:0] CURSOR_ATTR_RESET = 8'h07;

    // Action codes
    localparam logic [2:0] ACT_PUT_CHAR   = 3'd0;
    localparam logic [2:0] ACT_CLEAR      = 3'd1;
    localparam logic [2:0] ACT_CURSOR_ON  = 3'd2;
    localparam logic [2:0] ACT_CURSOR_OFF = 3'd3;
    localparam logic [2:0] ACT_SET_POS    = 3'd4;
    localparam logic [2:0] ACT_READ_CELL  = 3'd5;

    // Configuration register indexes
    localparam int         CFG_INDEX_W         = 2;
    localparam logic [1:0] CFG_IDX_TEXT_ATTR   = 2'd0;
    localparam logic [1:0] CFG_IDX_CURSOR_ATTR = 2'd1;

    // Cell memory write enables
    typedef struct packed {
        logic char_en;
        logic attr_en;
    } mem_wr_t;

endpackage

`default_nettype wire

>>> rtl/tce_cell_mem.sv
// Screen cell memory: character and attribute arrays, one write and one read port.
`timescale 1ns / 1ps
`default_nettype none

module tce_cell_mem
    import tce_pkg::*;
#(
    parameter int DEPTH  = DEF_SCREEN_COLUMNS * DEF_SCREEN_ROWS,
    parameter int ADDR_W = $clog2(DEPTH)
)
(
    input  wire logic              clk,
    input  wire mem_wr_t           wr,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [7:0]        wr_char,
    input  wire logic [7:0]        wr_attr,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output      logic [7:0]        rd_char,
    output      logic [7:0]        rd_attr
);

    logic [7:0] char_mem [DEPTH];
    logic [7:0] attr_mem [DEPTH];
    logic [7:0] rd_char_reg;
    logic [7:0] rd_attr_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr.char_en)
        begin
            char_mem[wr_addr] <= wr_char;
        end
        if (wr.attr_en)
        begin
            attr_mem[wr_addr] <= wr_attr;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_char_reg <= char_mem[rd_addr];
            rd_attr_reg <= attr_mem[rd_addr];
        end
    end

    assign rd_char = rd_char_reg;
    assign rd_attr = rd_attr_reg;

endmodule

`default_nettype wire

>>> rtl/text_console_engine.sv
// Text console engine top level: action sequencer, cursor state and cell sweeps.
//
//  Channel   Handshake                  Payload
//  -------   -------------------------  ------------------------------------------
//  command   start / busy               action, char_code, column, row
//  result    done (one-cycle strobe)    read_char, read_attribute, cursor_column,
//                                       cursor_row, cursor_shown
//  config    cfg_valid / cfg_ready      cfg_index, cfg_data
//
// A plain action passes through the address, execute and response states; a read or
// a backspace adds one state between. A clear, or a put that scrolls, adds a sweep
// over every cell, one cell per cycle through the single write port of the cell
// memory. After reset a clearing pass fills the screen with spaces; busy is high
// meanwhile.
// Config writes are taken in any cycle. The receiver cannot stall results.
`timescale 1ns / 1ps
`default_nettype none

module text_console_engine
    import tce_pkg::*;
#(
    parameter int SCREEN_COLUMNS = DEF_SCREEN_COLUMNS,
    parameter int SCREEN_ROWS    = DEF_SCREEN_ROWS,
    localparam int COL_W         = $clog2(SCREEN_COLUMNS),
    localparam int ROW_W         = $clog2(SCREEN_ROWS)
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // command channel
    input  wire logic                   start,
    output      logic                   busy,
    input  wire logic [2:0]             action,
    input  wire logic [7:0]             char_code,
    input  wire logic [COL_W-1:0]       column,
    input  wire logic [ROW_W-1:0]       row,
    // result channel
    output      logic                   done,
    output      logic [7:0]             read_char,
    output      logic [7:0]             read_attribute,
    output      logic [COL_W-1:0]       cursor_column,
    output      logic [ROW_W-1:0]       cursor_row,
    output      logic                   cursor_shown,
    // config channel
    input  wire logic                   cfg_valid,
    output      logic                   cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [7:0]             cfg_data
);

    localparam int CELLS  = SCREEN_COLUMNS * SCREEN_ROWS;
    localparam int CELL_W = $clog2(CELLS);

    localparam logic [CELL_W-1:0] COLS_C        = CELL_W'(SCREEN_COLUMNS);
    localparam logic [CELL_W-1:0] CELL_LAST     = CELL_W'(CELLS - 1);
    localparam logic [CELL_W-1:0] COPY_END      = CELL_W'(CELLS - SCREEN_COLUMNS);
    localparam logic [CELL_W-1:0] LAST_ROW_CELL = CELL_W'((SCREEN_ROWS - 1) * SCREEN_COLUMNS);
    localparam logic [COL_W-1:0]  COL_LAST      = COL_W'(SCREEN_COLUMNS - 1);
    localparam logic [ROW_W-1:0]  ROW_LAST      = ROW_W'(SCREEN_ROWS - 1);
    localparam logic [COL_W:0]    COL_LIMIT     = (COL_W + 1)'(SCREEN_COLUMNS);
    localparam logic [ROW_W:0]    ROW_LIMIT     = (ROW_W + 1)'(SCREEN_ROWS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADDR,
        ST_EXEC,
        ST_BS_FILL,
        ST_READ,
        ST_SWEEP,
        ST_DRAIN,
        ST_RESP
    } state_t;

    state_t state_reg, state_next;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [2:0]        act_reg, act_next;
    logic [7:0]        code_reg, code_next;
    logic [COL_W-1:0]  in_col_reg, in_col_next;
    logic [ROW_W-1:0]  in_row_reg, in_row_next;
    logic [CELL_W-1:0] tgt_cell_reg, tgt_cell_next;
    logic [COL_W-1:0]  tgt_col_reg, tgt_col_next;
    logic [ROW_W-1:0]  tgt_row_reg, tgt_row_next;
    logic [CELL_W-1:0] cur_cell_reg, cur_cell_next;
    logic [COL_W-1:0]  cur_col_reg, cur_col_next;
    logic [ROW_W-1:0]  cur_row_reg, cur_row_next;
    logic              cur_en_reg, cur_en_next;
    logic [7:0]        text_attr_reg, text_attr_next;
    logic [7:0]        cursor_attr_reg, cursor_attr_next;
    logic [7:0]        res_char_reg, res_char_next;
    logic [7:0]        res_attr_reg, res_attr_next;
    logic [CELL_W-1:0] scan_reg, scan_next;
    logic              scroll_mode_reg, scroll_mode_next;
    logic              init_mode_reg, init_mode_next;
    logic              pend_valid_reg, pend_valid_next;
    logic              pend_copy_reg, pend_copy_next;
    logic [CELL_W-1:0] pend_addr_reg, pend_addr_next;
    logic [7:0]        out_char_reg, out_char_next;
    logic [7:0]        out_attr_reg, out_attr_next;
    logic [COL_W-1:0]  out_col_reg, out_col_next;
    logic [ROW_W-1:0]  out_row_reg, out_row_next;
    logic              out_shown_reg, out_shown_next;

    // memory port signals
    mem_wr_t           mem_wr;
    logic [CELL_W-1:0] wr_addr;
    logic [7:0]        wr_char;
    logic [7:0]        wr_attr;
    logic              rd_en;
    logic [CELL_W-1:0] rd_addr;
    logic [7:0]        rd_char;
    logic [7:0]        rd_attr;

    // clamped input position
    logic [COL_W-1:0]  clamp_col;
    logic [ROW_W-1:0]  clamp_row;

    assign clamp_col = ({1'b0, in_col_reg} >= COL_LIMIT) ? COL_LAST : in_col_reg;
    assign clamp_row = ({1'b0, in_row_reg} >= ROW_LIMIT) ? ROW_LAST : in_row_reg;

    tce_cell_mem #(
        .DEPTH  (CELLS),
        .ADDR_W (CELL_W)
    ) u_cell_mem (
        .clk     (clk),
        .wr      (mem_wr),
        .wr_addr (wr_addr),
        .wr_char (wr_char),
        .wr_attr (wr_attr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_char (rd_char),
        .rd_attr (rd_attr)
    );

    // Sequencer next-state and memory control
    always_comb
    begin
        state_next       = state_reg;
        busy_next        = busy_reg;
        done_next        = 1'b0;
        act_next         = act_reg;
        code_next        = code_reg;
        in_col_next      = in_col_reg;
        in_row_next      = in_row_reg;
        tgt_cell_next    = tgt_cell_reg;
        tgt_col_next     = tgt_col_reg;
        tgt_row_next     = tgt_row_reg;
        cur_cell_next    = cur_cell_reg;
        cur_col_next     = cur_col_reg;
        cur_row_next     = cur_row_reg;
        cur_en_next      = cur_en_reg;
        text_attr_next   = text_attr_reg;
        cursor_attr_next = cursor_attr_reg;
        res_char_next    = res_char_reg;
        res_attr_next    = res_attr_reg;
        scan_next        = scan_reg;
        scroll_mode_next = scroll_mode_reg;
        init_mode_next   = init_mode_reg;
        pend_valid_next  = 1'b0;
        pend_copy_next   = pend_copy_reg;
        pend_addr_next   = pend_addr_reg;
        out_char_next    = out_char_reg;
        out_attr_next    = out_attr_reg;
        out_col_next     = out_col_reg;
        out_row_next     = out_row_reg;
        out_shown_next   = out_shown_reg;

        mem_wr  = '0;
        wr_addr = cur_cell_reg;
        wr_char = CHAR_SPACE;
        wr_attr = text_attr_reg;
        rd_en   = 1'b0;
        rd_addr = scan_reg + COLS_C;

        // config writes
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_IDX_TEXT_ATTR:   text_attr_next   = cfg_data;
                CFG_IDX_CURSOR_ATTR: cursor_attr_next = cfg_data;
                default:             ;
            endcase
        end

        // sweep write, the cycle after its read
        if (pend_valid_reg)
        begin
            mem_wr  = '{char_en: 1'b1, attr_en: 1'b1};
            wr_addr = pend_addr_reg;
            if (pend_copy_reg)
            begin
                wr_char = rd_char;
                wr_attr = rd_attr;
            end
            else
            begin
                wr_attr = init_mode_reg ? TEXT_ATTR_RESET : text_attr_reg;
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    act_next      = action;
                    code_next     = char_code;
                    in_col_next   = column;
                    in_row_next   = row;
                    res_char_next = '0;
                    res_attr_next = '0;
                    busy_next     = 1'b1;
                    state_next    = ST_ADDR;
                end
            end

            // linear target cell from the clamped position
            ST_ADDR:
            begin
                tgt_col_next  = clamp_col;
                tgt_row_next  = clamp_row;
                tgt_cell_next = CELL_W'(clamp_row) * COLS_C + CELL_W'(clamp_col);
                state_next    = ST_EXEC;
            end

            ST_EXEC:
            begin
                state_next = ST_RESP;
                case (act_reg)
                    ACT_PUT_CHAR:
                    begin
                        if (code_reg == CHAR_LF)
                        begin
                            mem_wr.attr_en = 1'b1;
                            cur_col_next   = '0;
                            if (cur_row_reg == ROW_LAST)
                            begin
                                cur_cell_next    = LAST_ROW_CELL;
                                scan_next        = '0;
                                scroll_mode_next = 1'b1;
                                state_next       = ST_SWEEP;
                            end
                            else
                            begin
                                cur_row_next  = cur_row_reg + 1'b1;
                                cur_cell_next = cur_cell_reg - CELL_W'(cur_col_reg) + COLS_C;
                            end
                        end
                        else if (code_reg == CHAR_BS)
                        begin
                            if (cur_cell_reg != '0)
                            begin
                                mem_wr.attr_en = 1'b1;
                                cur_cell_next  = cur_cell_reg - 1'b1;
                                if (cur_col_reg == '0)
                                begin
                                    cur_col_next = COL_LAST;
                                    cur_row_next = cur_row_reg - 1'b1;
                                end
                                else
                                begin
                                    cur_col_next = cur_col_reg - 1'b1;
                                end
                                state_next = ST_BS_FILL;
                            end
                        end
                        else if (code_reg != CHAR_NUL)
                        begin
                            mem_wr  = '{char_en: 1'b1, attr_en: 1'b1};
                            wr_char = code_reg;
                            if (cur_cell_reg == CELL_LAST)
                            begin
                                cur_cell_next    = LAST_ROW_CELL;
                                cur_col_next     = '0;
                                cur_row_next     = ROW_LAST;
                                scan_next        = '0;
                                scroll_mode_next = 1'b1;
                                state_next       = ST_SWEEP;
                            end
                            else
                            begin
                                cur_cell_next = cur_cell_reg + 1'b1;
                                if (cur_col_reg == COL_LAST)
                                begin
                                    cur_col_next = '0;
                                    cur_row_next = cur_row_reg + 1'b1;
                                end
                                else
                                begin
                                    cur_col_next = cur_col_reg + 1'b1;
                                end
                            end
                        end
                    end

                    ACT_CLEAR:
                    begin
                        cur_cell_next    = '0;
                        cur_col_next     = '0;
                        cur_row_next     = '0;
                        scan_next        = '0;
                        scroll_mode_next = 1'b0;
                        state_next       = ST_SWEEP;
                    end

                    ACT_CURSOR_ON:
                    begin
                        cur_en_next = 1'b1;
                    end

                    ACT_CURSOR_OFF:
                    begin
                        cur_en_next    = 1'b0;
                        mem_wr.attr_en = 1'b1;
                    end

                    ACT_SET_POS:
                    begin
                        mem_wr.attr_en = 1'b1;
                        cur_cell_next  = tgt_cell_reg;
                        cur_col_next   = tgt_col_reg;
                        cur_row_next   = tgt_row_reg;
                    end

                    ACT_READ_CELL:
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = tgt_cell_reg;
                        state_next = ST_READ;
                    end

                    default: ;
                endcase
            end

            // blank the cell stepped back onto, keeping its attribute
            ST_BS_FILL:
            begin
                mem_wr.char_en = 1'b1;
                wr_addr        = cur_cell_reg;
                wr_char        = CHAR_SPACE;
                state_next     = ST_RESP;
            end

            ST_READ:
            begin
                res_char_next = rd_char;
                res_attr_next = (cur_en_reg && (tgt_cell_reg == cur_cell_reg)) ?
                                cursor_attr_reg : rd_attr;
                state_next    = ST_RESP;
            end

            // one cell per cycle: read a row below (scrolling, above the last row), write here next cycle
            ST_SWEEP:
            begin
                rd_en           = scroll_mode_reg && (scan_reg < COPY_END);
                pend_valid_next = 1'b1;
                pend_copy_next  = scroll_mode_reg && (scan_reg < COPY_END);
                pend_addr_next  = scan_reg;
                if (scan_reg == CELL_LAST)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end

            ST_DRAIN:
            begin
                if (init_mode_reg)
                begin
                    init_mode_next = 1'b0;
                    busy_next      = 1'b0;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    state_next = ST_RESP;
                end
            end

            ST_RESP:
            begin
                done_next      = 1'b1;
                out_char_next  = res_char_reg;
                out_attr_next  = res_attr_reg;
                out_col_next   = cur_col_reg;
                out_row_next   = cur_row_reg;
                out_shown_next = cur_en_reg;
                busy_next      = 1'b0;
                state_next     = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_SWEEP;
            busy_reg        <= 1'b1;
            done_reg        <= 1'b0;
            cur_cell_reg    <= '0;
            cur_col_reg     <= '0;
            cur_row_reg     <= '0;
            cur_en_reg      <= 1'b1;
            text_attr_reg   <= TEXT_ATTR_RESET;
            cursor_attr_reg <= CURSOR_ATTR_RESET;
            scan_reg        <= '0;
            scroll_mode_reg <= 1'b0;
            init_mode_reg   <= 1'b1;
            pend_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            busy_reg        <= busy_next;
            done_reg        <= done_next;
            cur_cell_reg    <= cur_cell_next;
            cur_col_reg     <= cur_col_next;
            cur_row_reg     <= cur_row_next;
            cur_en_reg      <= cur_en_next;
            text_attr_reg   <= text_attr_next;
            cursor_attr_reg <= cursor_attr_next;
            scan_reg        <= scan_next;
            scroll_mode_reg <= scroll_mode_next;
            init_mode_reg   <= init_mode_next;
            pend_valid_reg  <= pend_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        act_reg       <= act_next;
        code_reg      <= code_next;
        in_col_reg    <= in_col_next;
        in_row_reg    <= in_row_next;
        tgt_cell_reg  <= tgt_cell_next;
        tgt_col_reg   <= tgt_col_next;
        tgt_row_reg   <= tgt_row_next;
        res_char_reg  <= res_char_next;
        res_attr_reg  <= res_attr_next;
        pend_copy_reg <= pend_copy_next;
        pend_addr_reg <= pend_addr_next;
        out_char_reg  <= out_char_next;
        out_attr_reg  <= out_attr_next;
        out_col_reg   <= out_col_next;
        out_row_reg   <= out_row_next;
        out_shown_reg <= out_shown_next;
    end

    assign busy           = busy_reg;
    assign done           = done_reg;
    assign cfg_ready      = 1'b1;
    assign read_char      = out_char_reg;
    assign read_attribute = out_attr_reg;
    assign cursor_column  = out_col_reg;
    assign cursor_row     = out_row_reg;
    assign cursor_shown   = out_shown_reg;

`ifndef SYNTH
    // an accepted transaction keeps the block busy in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accepted command");

    // a result strobe only follows the response state
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(state_reg) == ST_RESP) && !busy)
        else $error("result strobe outside response");

    // linear cursor cell agrees with row and column
    assert property (@(posedge clk) disable iff (!rst_n)
        cur_cell_reg == CELL_W'(cur_row_reg) * COLS_C + CELL_W'(cur_col_reg))
        else $error("cursor cell out of step with row and column");

    // cursor stays on the screen
    assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, cur_col_reg} < COL_LIMIT) && ({1'b0, cur_row_reg} < ROW_LIMIT))
        else $error("cursor off screen");
`endif

endmodule

`default_nettype wire
